### rtl/ppj_pkg.sv
// shared constants and types for the pressure poisson jacobi sweep
`default_nettype none

package ppj_pkg;

    // grid geometry
    localparam int MAX_COLS = 1024;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int LEN_W    = $clog2(MAX_COLS + 1);
    localparam int ROW_W    = 16;
    localparam int MIN_GRID = 3;

    // sample and weight formats
    localparam int SAMPLE_W = 32;
    localparam int COEF_W   = 24;
    localparam int SUM_W    = SAMPLE_W + 1;
    localparam int PROD_W   = COEF_W + 1 + SUM_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int Q_W      = ACC_W - COEF_W;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_COL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_ROW   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_SRC   = 3'd4;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_ROW_LENGTH = LEN_W'(41);
    localparam logic [ROW_W-1:0]  RST_ROW_COUNT  = ROW_W'(43);
    localparam logic [COEF_W-1:0] RST_COEF_COL   = COEF_W'(4194304);
    localparam logic [COEF_W-1:0] RST_COEF_ROW   = COEF_W'(4194304);
    localparam logic [COEF_W-1:0] RST_COEF_SRC   = COEF_W'(10486);

    // stencil weights
    typedef struct packed {
        logic [COEF_W-1:0] col_pair;
        logic [COEF_W-1:0] row_pair;
        logic [COEF_W-1:0] source;
    } t_coefs;

    // one stencil point ready for the arithmetic
    typedef struct packed {
        logic signed [SUM_W-1:0]    sum_col;
        logic signed [SUM_W-1:0]    sum_row;
        logic signed [SAMPLE_W-1:0] src;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       first;
        logic                       last;
    } t_work;

endpackage

`default_nettype wire

### rtl/ppj_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ppj_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/ppj_front.sv
// front end: grid counters, row buffers and stencil point classification
`default_nettype none

module ppj_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [ppj_pkg::SAMPLE_W-1:0] i_p_old,
    input  wire logic signed [ppj_pkg::SAMPLE_W-1:0] i_source_term,
    input  wire logic [ppj_pkg::LEN_W-1:0]           i_row_length,
    input  wire logic [ppj_pkg::ROW_W-1:0]           i_row_count,
    input  wire logic [ppj_pkg::QCNT_W-1:0]          i_q_count,
    output logic                                     o_push,
    output ppj_pkg::t_work                           o_work
);

    logic [ppj_pkg::COL_W-1:0]    r_col;
    logic [ppj_pkg::ROW_W-1:0]    r_row;
    logic [ppj_pkg::COL_W-1:0]    n_col;
    logic [ppj_pkg::ROW_W-1:0]    n_row;
    logic [ppj_pkg::LEN_W-1:0]    w_len;
    logic [ppj_pkg::ROW_W-1:0]    w_rows;
    logic [ppj_pkg::LEN_W-1:0]    w_col_ext;
    logic [ppj_pkg::LEN_W-1:0]    w_col_p1;
    logic [ppj_pkg::LEN_W-1:0]    w_col_p2;
    logic [ppj_pkg::ROW_W:0]      w_row_p1;
    logic [ppj_pkg::QCNT_W:0]     w_credit;
    logic                         w_accept;
    logic                         w_in_range;
    logic                         w_emit;
    logic [ppj_pkg::COL_W-1:0]    w_col_next_addr;

    // stage one registers
    logic                         r_s1_valid;
    logic                         r_s1_wr;
    logic                         r_s1_emit;
    logic                         r_s1_first;
    logic                         r_s1_last;
    logic [ppj_pkg::COL_W-1:0]    r_s1_col;
    logic [ppj_pkg::ROW_W-1:0]    r_s1_row;
    logic [ppj_pkg::SAMPLE_W-1:0] r_s1_down;
    logic [ppj_pkg::SAMPLE_W-1:0] r_s1_src;
    logic signed [ppj_pkg::SAMPLE_W-1:0] r_left;

    // row buffer read data
    logic [ppj_pkg::SAMPLE_W-1:0] w_mid;
    logic [ppj_pkg::SAMPLE_W-1:0] w_right;
    logic [ppj_pkg::SAMPLE_W-1:0] w_up;
    logic [ppj_pkg::SAMPLE_W-1:0] w_src_buf;
    logic                         w_wr;

    // effective grid size
    always_comb begin
        if (i_row_length < ppj_pkg::LEN_W'(ppj_pkg::MIN_GRID)) begin
            w_len = ppj_pkg::LEN_W'(ppj_pkg::MIN_GRID);
        end else if (i_row_length > ppj_pkg::LEN_W'(ppj_pkg::MAX_COLS)) begin
            w_len = ppj_pkg::LEN_W'(ppj_pkg::MAX_COLS);
        end else begin
            w_len = i_row_length;
        end
    end

    assign w_rows = (i_row_count < ppj_pkg::ROW_W'(ppj_pkg::MIN_GRID))
                  ? ppj_pkg::ROW_W'(ppj_pkg::MIN_GRID) : i_row_count;

    // accept while the queue has room for everything in flight
    assign w_credit   = (ppj_pkg::QCNT_W + 1)'(i_q_count)
                      + (ppj_pkg::QCNT_W + 1)'(r_s1_valid);
    assign o_in_ready = (w_credit < (ppj_pkg::QCNT_W + 1)'(ppj_pkg::QUEUE_DEPTH));
    assign w_accept   = i_in_valid && o_in_ready;

    // position classification
    assign w_col_ext  = ppj_pkg::LEN_W'(r_col);
    assign w_col_p1   = w_col_ext + ppj_pkg::LEN_W'(1);
    assign w_col_p2   = w_col_ext + ppj_pkg::LEN_W'(2);
    assign w_row_p1   = {1'b0, r_row} + (ppj_pkg::ROW_W + 1)'(1);
    assign w_in_range = (w_col_ext < w_len);
    assign w_emit     = (r_row >= ppj_pkg::ROW_W'(2)) && (r_row < w_rows)
                     && (r_col != '0) && (w_col_p1 < w_len);

    // raster counters
    always_comb begin
        n_col = w_col_p1[ppj_pkg::COL_W-1:0];
        n_row = r_row;
        if (w_col_p1 >= w_len) begin
            n_col = '0;
            if (w_row_p1 >= {1'b0, w_rows}) begin
                n_row = '0;
            end else begin
                n_row = w_row_p1[ppj_pkg::ROW_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage one capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_wr    <= w_in_range;
            r_s1_emit  <= w_emit;
            r_s1_first <= (r_col == ppj_pkg::COL_W'(1));
            r_s1_last  <= (w_col_p2 == w_len);
            r_s1_col   <= r_col;
            r_s1_row   <= r_row - ppj_pkg::ROW_W'(1);
            r_s1_down  <= i_p_old;
            r_s1_src   <= i_source_term;
        end
    end

    // row buffers, read at the counter, written in the following cycle
    assign w_col_next_addr = r_col + ppj_pkg::COL_W'(1);
    assign w_wr            = r_s1_valid && r_s1_wr;

    ppj_ram #(.WIDTH(ppj_pkg::SAMPLE_W), .DEPTH(ppj_pkg::MAX_COLS)) u_newer_mid (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_down),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_mid)
    );

    ppj_ram #(.WIDTH(ppj_pkg::SAMPLE_W), .DEPTH(ppj_pkg::MAX_COLS)) u_newer_right (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_down),
        .i_re    (w_accept),
        .i_raddr (w_col_next_addr),
        .o_rdata (w_right)
    );

    ppj_ram #(.WIDTH(ppj_pkg::SAMPLE_W), .DEPTH(ppj_pkg::MAX_COLS)) u_older (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_s1_col),
        .i_wdata (w_mid),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_up)
    );

    ppj_ram #(.WIDTH(ppj_pkg::SAMPLE_W), .DEPTH(ppj_pkg::MAX_COLS)) u_source (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_src),
        .i_re    (w_accept),
        .i_raddr (r_col),
        .o_rdata (w_src_buf)
    );

    // left neighbor is the previous column of the middle row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (w_wr) begin
            r_left <= $signed(w_mid);
        end
    end

    // operand pre-add and request to the queue
    assign o_push         = r_s1_valid && r_s1_emit;
    assign o_work.sum_col = ppj_pkg::SUM_W'(r_left) + ppj_pkg::SUM_W'($signed(w_right));
    assign o_work.sum_row = ppj_pkg::SUM_W'($signed(w_up)) + ppj_pkg::SUM_W'($signed(r_s1_down));
    assign o_work.src     = $signed(w_src_buf);
    assign o_work.row     = r_s1_row;
    assign o_work.col     = r_s1_col;
    assign o_work.first   = r_s1_first;
    assign o_work.last    = r_s1_last;

`ifndef ASSERT_OFF
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_q_count < ppj_pkg::QCNT_W'(ppj_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

### rtl/ppj_queue.sv
// small flip-flop fifo between front and back
`default_nettype none

module ppj_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire ppj_pkg::t_work              i_work,
    input  wire logic                        i_pop,
    output logic                             o_valid,
    output ppj_pkg::t_work                   o_work,
    output logic [ppj_pkg::QCNT_W-1:0]       o_count
);

    ppj_pkg::t_work                r_mem [ppj_pkg::QUEUE_DEPTH];
    logic [ppj_pkg::QPTR_W-1:0]    r_wptr;
    logic [ppj_pkg::QPTR_W-1:0]    r_rptr;
    logic [ppj_pkg::QCNT_W-1:0]    r_count;
    logic [ppj_pkg::QPTR_W-1:0]    n_wptr;
    logic [ppj_pkg::QPTR_W-1:0]    n_rptr;

    // pointer wrap
    assign n_wptr = (r_wptr == ppj_pkg::QPTR_W'(ppj_pkg::QUEUE_DEPTH - 1))
                  ? '0 : r_wptr + ppj_pkg::QPTR_W'(1);
    assign n_rptr = (r_rptr == ppj_pkg::QPTR_W'(ppj_pkg::QUEUE_DEPTH - 1))
                  ? '0 : r_rptr + ppj_pkg::QPTR_W'(1);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_work;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + ppj_pkg::QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - ppj_pkg::QCNT_W'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rptr];
    assign o_count = r_count;

`ifndef ASSERT_OFF
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

### rtl/ppj_back.sv
// back end: weighted sum, rounding, saturation and wall column expansion
`default_nettype none

module ppj_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_q_valid,
    input  wire ppj_pkg::t_work                 i_q_work,
    output logic                                o_pop,
    input  wire ppj_pkg::t_coefs                i_coefs,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic signed [ppj_pkg::SAMPLE_W-1:0] o_p_new,
    output logic [ppj_pkg::ROW_W-1:0]           o_row_index,
    output logic [ppj_pkg::COL_W-1:0]           o_col_index,
    output logic                                o_run_last
);

    // pending result bits of one stencil point
    localparam int MASK_FIRST = 0;
    localparam int MASK_MAIN  = 1;
    localparam int MASK_LAST  = 2;

    localparam logic signed [ppj_pkg::ACC_W-1:0] ROUND_BIAS =
        ppj_pkg::ACC_W'(1) << (ppj_pkg::COEF_W - 1);
    localparam logic signed [ppj_pkg::SAMPLE_W-1:0] SAT_MAX =
        {1'b0, {(ppj_pkg::SAMPLE_W - 1){1'b1}}};
    localparam logic signed [ppj_pkg::SAMPLE_W-1:0] SAT_MIN =
        {1'b1, {(ppj_pkg::SAMPLE_W - 1){1'b0}}};

    // multiply stage
    logic                                 r_m_valid;
    logic signed [ppj_pkg::PROD_W-1:0]    r_m_pc;
    logic signed [ppj_pkg::PROD_W-1:0]    r_m_pr;
    logic signed [ppj_pkg::PROD_W-1:0]    r_m_ps;
    logic [ppj_pkg::ROW_W-1:0]            r_m_row;
    logic [ppj_pkg::COL_W-1:0]            r_m_col;
    logic                                 r_m_first;
    logic                                 r_m_last;

    // sum stage
    logic                                 r_s_valid;
    logic signed [ppj_pkg::ACC_W-1:0]     r_s_sum;
    logic [ppj_pkg::ROW_W-1:0]            r_s_row;
    logic [ppj_pkg::COL_W-1:0]            r_s_col;
    logic                                 r_s_first;
    logic                                 r_s_last;

    // expansion stage
    logic                                 r_e_valid;
    logic signed [ppj_pkg::SAMPLE_W-1:0]  r_e_p;
    logic [ppj_pkg::ROW_W-1:0]            r_e_row;
    logic [ppj_pkg::COL_W-1:0]            r_e_col;
    logic [2:0]                           r_e_mask;

    // output register
    logic                                 r_o_valid;
    logic signed [ppj_pkg::SAMPLE_W-1:0]  r_o_p;
    logic [ppj_pkg::ROW_W-1:0]            r_o_row;
    logic [ppj_pkg::COL_W-1:0]            r_o_col;
    logic                                 r_o_last;

    logic signed [ppj_pkg::COEF_W:0]      w_cp;
    logic signed [ppj_pkg::COEF_W:0]      w_rp;
    logic signed [ppj_pkg::COEF_W:0]      w_cs;
    logic signed [ppj_pkg::PROD_W-1:0]    w_pc;
    logic signed [ppj_pkg::PROD_W-1:0]    w_pr;
    logic signed [ppj_pkg::PROD_W-1:0]    w_ps;
    logic signed [ppj_pkg::ACC_W-1:0]     w_sum;
    logic signed [ppj_pkg::ACC_W-1:0]     w_rnd;
    logic signed [ppj_pkg::Q_W-1:0]       w_q;
    logic signed [ppj_pkg::SAMPLE_W-1:0]  w_sat;
    logic [2:0]                           n_mask;
    logic [ppj_pkg::COL_W-1:0]            w_emit_col;
    logic                                 w_o_load;
    logic                                 w_e_done;
    logic                                 w_e_ready;
    logic                                 w_s_ready;
    logic                                 w_m_ready;

    // elastic handshake from the output back to the queue
    assign w_o_load  = r_e_valid && (!r_o_valid || i_out_ready);
    assign w_e_done  = w_o_load && (n_mask == '0);
    assign w_e_ready = !r_e_valid || w_e_done;
    assign w_s_ready = !r_s_valid || w_e_ready;
    assign w_m_ready = !r_m_valid || w_s_ready;
    assign o_pop     = i_q_valid && w_m_ready;

    // weight products
    assign w_cp = $signed({1'b0, i_coefs.col_pair});
    assign w_rp = $signed({1'b0, i_coefs.row_pair});
    assign w_cs = $signed({1'b0, i_coefs.source});
    assign w_pc = w_cp * i_q_work.sum_col;
    assign w_pr = w_rp * i_q_work.sum_row;
    assign w_ps = ppj_pkg::PROD_W'(w_cs * i_q_work.src);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_m_ready) begin
            r_m_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_pc    <= w_pc;
            r_m_pr    <= w_pr;
            r_m_ps    <= w_ps;
            r_m_row   <= i_q_work.row;
            r_m_col   <= i_q_work.col;
            r_m_first <= i_q_work.first;
            r_m_last  <= i_q_work.last;
        end
    end

    // three term sum
    assign w_sum = ppj_pkg::ACC_W'(r_m_pc) + ppj_pkg::ACC_W'(r_m_pr)
                 - ppj_pkg::ACC_W'(r_m_ps);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (w_s_ready) begin
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_ready && r_m_valid) begin
            r_s_sum   <= w_sum;
            r_s_row   <= r_m_row;
            r_s_col   <= r_m_col;
            r_s_first <= r_m_first;
            r_s_last  <= r_m_last;
        end
    end

    // round half up to q16.16 and saturate
    assign w_rnd = r_s_sum + ROUND_BIAS;
    assign w_q   = w_rnd[ppj_pkg::ACC_W-1:ppj_pkg::COEF_W];

    always_comb begin
        if (w_q[ppj_pkg::Q_W-1:ppj_pkg::SAMPLE_W-1]
                == {(ppj_pkg::Q_W - ppj_pkg::SAMPLE_W + 1){w_q[ppj_pkg::SAMPLE_W-1]}}) begin
            w_sat = w_q[ppj_pkg::SAMPLE_W-1:0];
        end else if (w_q[ppj_pkg::Q_W-1]) begin
            w_sat = SAT_MIN;
        end else begin
            w_sat = SAT_MAX;
        end
    end

    // pick the next column to emit, walls around the main point
    always_comb begin
        n_mask     = r_e_mask;
        w_emit_col = r_e_col + ppj_pkg::COL_W'(1);
        priority if (r_e_mask[MASK_FIRST]) begin
            n_mask[MASK_FIRST] = 1'b0;
            w_emit_col         = '0;
        end else if (r_e_mask[MASK_MAIN]) begin
            n_mask[MASK_MAIN] = 1'b0;
            w_emit_col        = r_e_col;
        end else begin
            n_mask[MASK_LAST] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_e_mask  <= '0;
        end else if (w_e_ready) begin
            r_e_valid <= r_s_valid;
            r_e_mask  <= {r_s_last, 1'b1, r_s_first};
        end else if (w_o_load) begin
            r_e_mask  <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_ready && r_s_valid) begin
            r_e_p   <= w_sat;
            r_e_row <= r_s_row;
            r_e_col <= r_s_col;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_o_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_load) begin
            r_o_p    <= r_e_p;
            r_o_row  <= r_e_row;
            r_o_col  <= w_emit_col;
            r_o_last <= (n_mask == '0);
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_p_new     = r_o_p;
    assign o_row_index = r_o_row;
    assign o_col_index = r_o_col;
    assign o_run_last  = r_o_last;

`ifndef ASSERT_OFF
    a_mask_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_valid |-> (r_e_mask != '0))
        else $error("expansion entry with nothing to emit");

    a_first_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_e_valid && r_e_mask[MASK_FIRST]) |-> (r_e_col == ppj_pkg::COL_W'(1)))
        else $error("left wall copy from a column other than one");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_e_done |=> (r_o_valid && r_o_last))
        else $error("finished entry without a closing result");
`endif

endmodule

`default_nettype wire

### rtl/pressure_poisson_jacobi_sweep.sv
// top level of the pressure poisson jacobi sweep with its register file
//
// Streams one Jacobi sweep of the pressure Poisson equation in raster order,
// one grid point (old pressure and source term, Q16.16) per request. The point
// arriving at (r, c) finishes point (r-1, c) with the 5-point stencil
// cp*(left+right) + rp*(up+down) - cs*source, weights Q0.24, rounded half up
// and saturated to 32 bits. Halo rows and wall-column inputs give no result;
// column 1 also yields the copy for column 0 and column row_length-2 the copy
// for the last column, so a point yields 0 to 3 results with run_last on the
// final one. The input side takes one request per clock; the output register
// delivers one result per clock while i_out_ready is high, so a request near a
// row edge yields two or three results, and the input stalls only when the
// four-entry queue in front of the arithmetic, counting the request one stage
// ahead of it, is full. The row buffers are not cleared after reset: a sweep
// has to start at row 0, and configuration is to be written by the user only
// while the block is idle; the block does not enforce this.
`default_nettype none

module pressure_poisson_jacobi_sweep (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ppj_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  wire logic [ppj_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [ppj_pkg::SAMPLE_W-1:0] i_p_old,
    input  wire logic signed [ppj_pkg::SAMPLE_W-1:0] i_source_term,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [ppj_pkg::SAMPLE_W-1:0]      o_p_new,
    output logic [ppj_pkg::ROW_W-1:0]                o_row_index,
    output logic [ppj_pkg::COL_W-1:0]                o_col_index,
    output logic                                     o_run_last
);

    logic [ppj_pkg::LEN_W-1:0]  r_row_length;
    logic [ppj_pkg::ROW_W-1:0]  r_row_count;
    ppj_pkg::t_coefs            r_coefs;

    logic                       w_push;
    ppj_pkg::t_work             w_push_work;
    logic                       w_pop;
    logic                       w_q_valid;
    ppj_pkg::t_work             w_q_work;
    logic [ppj_pkg::QCNT_W-1:0] w_q_count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length     <= ppj_pkg::RST_ROW_LENGTH;
            r_row_count      <= ppj_pkg::RST_ROW_COUNT;
            r_coefs.col_pair <= ppj_pkg::RST_COEF_COL;
            r_coefs.row_pair <= ppj_pkg::RST_COEF_ROW;
            r_coefs.source   <= ppj_pkg::RST_COEF_SRC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppj_pkg::REG_ROW_LENGTH: begin
                    r_row_length <= i_cfg_data[ppj_pkg::LEN_W-1:0];
                end
                ppj_pkg::REG_ROW_COUNT: begin
                    r_row_count <= i_cfg_data[ppj_pkg::ROW_W-1:0];
                end
                ppj_pkg::REG_COEF_COL: begin
                    r_coefs.col_pair <= i_cfg_data[ppj_pkg::COEF_W-1:0];
                end
                ppj_pkg::REG_COEF_ROW: begin
                    r_coefs.row_pair <= i_cfg_data[ppj_pkg::COEF_W-1:0];
                end
                ppj_pkg::REG_COEF_SRC: begin
                    r_coefs.source <= i_cfg_data[ppj_pkg::COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // counters, row buffers and classification
    ppj_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_p_old       (i_p_old),
        .i_source_term (i_source_term),
        .i_row_length  (r_row_length),
        .i_row_count   (r_row_count),
        .i_q_count     (w_q_count),
        .o_push        (w_push),
        .o_work        (w_push_work)
    );

    // decoupling queue
    ppj_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_work  (w_push_work),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_work  (w_q_work),
        .o_count (w_q_count)
    );

    // arithmetic and result expansion
    ppj_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_work    (w_q_work),
        .o_pop       (w_pop),
        .i_coefs     (r_coefs),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_p_new     (o_p_new),
        .o_row_index (o_row_index),
        .o_col_index (o_col_index),
        .o_run_last  (o_run_last)
    );

endmodule

`default_nettype wire
